[rtl/fixed_point_alu_core_defines.svh]
// Assertion macros shared by the checker of the fixed-point ALU core.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef FIXED_POINT_ALU_CORE_DEFINES_SVH
`define FIXED_POINT_ALU_CORE_DEFINES_SVH

// Property checked only while reset is released.
`define FPA_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every clock edge, during reset too.
`define FPA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/fpa_pkg.sv]
// Types and constants of the fixed-point ALU core.
// Depends on nothing; used by every module of the core.
package fpa_pkg;

    localparam int WORD_BITS = 16;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_SUB,
        CMD_MUL,
        CMD_DIV
    } fpa_cmd_t;

    typedef struct packed {
        fpa_cmd_t                    command;
        logic signed [WORD_BITS-1:0] operand_a;
        logic signed [WORD_BITS-1:0] operand_b;
    } fpa_req_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] result_word;
        logic                        divide_by_zero;
    } fpa_rsp_t;

    typedef struct packed {
        fpa_cmd_t              cmd;
        logic                  neg;
        logic                  dz;
        logic [WORD_BITS-1:0]  word;
    } fpa_ctrl_t;

endpackage

[rtl/fpa_prep.sv]
// Input stage: computes add, subtract and multiply results and prepares the divide operands.
// Depends on fpa_pkg.
module fpa_prep #(
    parameter int FRAC_BITS = 8,
    parameter int NB        = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid,
    input  fpa_pkg::fpa_req_t             data,
    input  logic                          down_ready,
    output logic                          ready,
    output logic                          valid_q,
    output fpa_pkg::fpa_ctrl_t            ctrl_q,
    output logic [fpa_pkg::WORD_BITS-1:0] rem_q,
    output logic [NB-1:0]                 num_q,
    output logic [fpa_pkg::WORD_BITS-1:0] div_q
);

    localparam int W = fpa_pkg::WORD_BITS;

    logic                  valid_reg;
    fpa_pkg::fpa_ctrl_t    ctrl_reg, ctrl_next;
    logic [NB-1:0]         num_reg, num_next;
    logic [W-1:0]          div_reg, div_next;
    logic signed [2*W-1:0] opa_x, opb_x, product;
    logic [W-1:0]          raw_a, raw_b, mag_a;

    assign ready = !valid_reg || down_ready;
    assign opa_x = {{W{data.operand_a[W-1]}}, data.operand_a};
    assign opb_x = {{W{data.operand_b[W-1]}}, data.operand_b};
    assign product = opa_x * opb_x;
    assign raw_a = data.operand_a;
    assign raw_b = data.operand_b;

    always_comb
    begin
        mag_a = raw_a[W-1] ? (~raw_a + 1'b1) : raw_a;
        div_next = raw_b[W-1] ? (~raw_b + 1'b1) : raw_b;
        num_next = NB'(mag_a) << FRAC_BITS;
        ctrl_next.cmd = data.command;
        ctrl_next.neg = raw_a[W-1] ^ raw_b[W-1];
        ctrl_next.dz = (data.command == fpa_pkg::CMD_DIV) && (raw_b == '0);
        case (data.command)
            fpa_pkg::CMD_ADD: ctrl_next.word = raw_a + raw_b;
            fpa_pkg::CMD_SUB: ctrl_next.word = raw_a - raw_b;
            fpa_pkg::CMD_MUL: ctrl_next.word = product[FRAC_BITS +: W];
            default:          ctrl_next.word = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && valid)
        begin
            ctrl_reg <= ctrl_next;
            num_reg  <= num_next;
            div_reg  <= div_next;
        end
    end

    assign valid_q = valid_reg;
    assign ctrl_q  = ctrl_reg;
    assign rem_q   = '0;
    assign num_q   = num_reg;
    assign div_q   = div_reg;

endmodule

[rtl/fpa_div_cell.sv]
// One restoring-division cell: produces one quotient bit and hands the item to the next cell.
// Depends on fpa_pkg.
module fpa_div_cell #(
    parameter int NB = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid,
    input  fpa_pkg::fpa_ctrl_t            ctrl,
    input  logic [fpa_pkg::WORD_BITS-1:0] rem,
    input  logic [NB-1:0]                 num,
    input  logic [fpa_pkg::WORD_BITS-1:0] div,
    input  logic                          down_ready,
    output logic                          ready,
    output logic                          valid_q,
    output fpa_pkg::fpa_ctrl_t            ctrl_q,
    output logic [fpa_pkg::WORD_BITS-1:0] rem_q,
    output logic [NB-1:0]                 num_q,
    output logic [fpa_pkg::WORD_BITS-1:0] div_q
);

    localparam int W = fpa_pkg::WORD_BITS;

    logic               valid_reg;
    fpa_pkg::fpa_ctrl_t ctrl_reg;
    logic [W-1:0]       rem_reg, rem_next;
    logic [NB-1:0]      num_reg, num_next;
    logic [W-1:0]       div_reg;
    logic [W:0]         trial, diff;
    logic               fits;

    assign ready = !valid_reg || down_ready;

    always_comb
    begin
        trial = {rem, num[NB-1]};
        diff = trial - {1'b0, div};
        fits = trial >= {1'b0, div};
        rem_next = fits ? diff[W-1:0] : trial[W-1:0];
        num_next = {num[NB-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && valid)
        begin
            ctrl_reg <= ctrl;
            rem_reg  <= rem_next;
            num_reg  <= num_next;
            div_reg  <= div;
        end
    end

    assign valid_q = valid_reg;
    assign ctrl_q  = ctrl_reg;
    assign rem_q   = rem_reg;
    assign num_q   = num_reg;
    assign div_q   = div_reg;

endmodule

[rtl/fpa_out.sv]
// Output stage: applies the quotient sign, selects the result and holds it for the transfer.
// Depends on fpa_pkg.
module fpa_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid,
    input  fpa_pkg::fpa_ctrl_t            ctrl,
    input  logic [fpa_pkg::WORD_BITS-1:0] quot,
    input  logic                          stall,
    output logic                          ready,
    output logic                          rsp_valid,
    output fpa_pkg::fpa_rsp_t             rsp
);

    localparam int W = fpa_pkg::WORD_BITS;

    logic              valid_reg;
    fpa_pkg::fpa_rsp_t rsp_reg, rsp_next;
    logic [W-1:0]      signed_quot;

    assign ready = !valid_reg || !stall;

    always_comb
    begin
        signed_quot = ctrl.neg ? (~quot + 1'b1) : quot;
        rsp_next.divide_by_zero = ctrl.dz;
        if (ctrl.cmd == fpa_pkg::CMD_DIV)
        begin
            rsp_next.result_word = ctrl.dz ? '0 : signed_quot;
        end
        else
        begin
            rsp_next.result_word = ctrl.word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && valid)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/fixed_point_alu_core.sv]
// Each item is registered in the input stage, one cell per quotient bit and the output stage.
// Throughput: one item per cycle while the response side does not stall.
// A stalled response backs up the chain cell by cell, and empty cells keep accepting.
// Reset clears every valid bit at once; there is no other state to restore.
// Top level of the fixed-point ALU core; depends on fpa_pkg, fpa_prep, fpa_div_cell, fpa_out.
module fixed_point_alu_core #(
    parameter int FRAC_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  fpa_pkg::fpa_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output fpa_pkg::fpa_rsp_t rsp
);

    localparam int W  = fpa_pkg::WORD_BITS;
    localparam int NB = W + FRAC_BITS;

    logic               st_valid [0:NB];
    fpa_pkg::fpa_ctrl_t st_ctrl  [0:NB];
    logic [W-1:0]       st_rem   [0:NB];
    logic [NB-1:0]      st_num   [0:NB];
    logic [W-1:0]       st_div   [0:NB];
    logic               st_ready [0:NB+1];

    fpa_prep #(
        .FRAC_BITS (FRAC_BITS),
        .NB        (NB)
    ) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (req_valid),
        .data       (req),
        .down_ready (st_ready[1]),
        .ready      (st_ready[0]),
        .valid_q    (st_valid[0]),
        .ctrl_q     (st_ctrl[0]),
        .rem_q      (st_rem[0]),
        .num_q      (st_num[0]),
        .div_q      (st_div[0])
    );

    for (genvar i = 0; i < NB; i++)
    begin : g_cell
        fpa_div_cell #(
            .NB (NB)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .valid      (st_valid[i]),
            .ctrl       (st_ctrl[i]),
            .rem        (st_rem[i]),
            .num        (st_num[i]),
            .div        (st_div[i]),
            .down_ready (st_ready[i+2]),
            .ready      (st_ready[i+1]),
            .valid_q    (st_valid[i+1]),
            .ctrl_q     (st_ctrl[i+1]),
            .rem_q      (st_rem[i+1]),
            .num_q      (st_num[i+1]),
            .div_q      (st_div[i+1])
        );
    end

    fpa_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (st_valid[NB]),
        .ctrl      (st_ctrl[NB]),
        .quot      (st_num[NB][W-1:0]),
        .stall     (rsp_stall),
        .ready     (st_ready[NB+1]),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    assign req_stall = !st_ready[0];

endmodule

[rtl/fpa_checker.sv]
// Port-level checker of the fixed-point ALU core and its bind to the top level.
// Depends on fpa_pkg and fixed_point_alu_core_defines.svh.
`include "fixed_point_alu_core_defines.svh"

module fpa_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input fpa_pkg::fpa_req_t req,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input fpa_pkg::fpa_rsp_t rsp
);

    // A response that is not taken stays in place unchanged.
    `FPA_ASSERT_RUN(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled response changed")

    // With the response side open, the whole chain moves and the request side never stalls.
    `FPA_ASSERT_RUN(a_flow_through, clk, rst_n, !rsp_stall |-> !req_stall, "request stalled while response side is open")

    // Once reset has been seen at an edge, no response shows and requests are taken.
    `FPA_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !rsp_valid && !req_stall, "core not empty in reset")

    // A divide-by-zero response always carries a zero word.
    `FPA_ASSERT_RUN(a_dz_zero, clk, rst_n, rsp_valid && rsp.divide_by_zero |-> rsp.result_word == '0 && !(req_valid && req_stall && !rst_n), "divide by zero with nonzero word")

endmodule

bind fixed_point_alu_core fpa_checker u_fpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

[tb/sv/tb_top.sv]
// Self-checking testbench for fixed_point_alu_core: directed table plus random operand pairs.
// Each result is typed in the table or predicted in the bench, and checked in order; depends on fpa_pkg and the core.
module tb_top;

    localparam int WORD_BITS = fpa_pkg::WORD_BITS;
    localparam int FRAC_BITS = 8;
    localparam int LATENCY = WORD_BITS + FRAC_BITS + 2;
    localparam int RANDOM_ITEMS = 1750;
    localparam bit TYPED = 1'b1;
    localparam bit PREDICTED = 1'b0;

    typedef struct {
        fpa_pkg::fpa_req_t stim;
        bit                typed;
        fpa_pkg::fpa_rsp_t answer;
    } table_row_t;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    fpa_pkg::fpa_req_t req;
    logic              rsp_valid;
    logic              rsp_stall;
    fpa_pkg::fpa_rsp_t rsp;

    table_row_t        item_table[$];
    fpa_pkg::fpa_rsp_t pending_results[$];
    fpa_pkg::fpa_rsp_t oldest_result;
    int                mismatch_count = 0;
    int                burst_left = 0;

    fixed_point_alu_core #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic fpa_pkg::fpa_rsp_t alu_result(input fpa_pkg::fpa_req_t item);
        logic signed [63:0] lhs;
        logic signed [63:0] rhs;
        logic signed [63:0] wide;
        fpa_pkg::fpa_rsp_t  answer;
        begin
            lhs = 64'(item.operand_a);
            rhs = 64'(item.operand_b);
            wide = '0;
            answer.divide_by_zero = 1'b0;
            case (item.command)
                fpa_pkg::CMD_ADD: wide = lhs + rhs;
                fpa_pkg::CMD_SUB: wide = lhs - rhs;
                fpa_pkg::CMD_MUL: wide = (lhs * rhs) >>> FRAC_BITS;
                fpa_pkg::CMD_DIV:
                begin
                    if (rhs == 0)
                        answer.divide_by_zero = 1'b1;
                    else
                        wide = (lhs <<< FRAC_BITS) / rhs;
                end
                default: wide = '0;
            endcase
            answer.result_word = wide[WORD_BITS-1:0];
            return answer;
        end
    endfunction

    function automatic logic [WORD_BITS-1:0] random_operand();
        int unsigned          kind;
        logic [WORD_BITS-1:0] pick;
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                case ($urandom_range(0, 6))
                    0: pick = 16'h8000;
                    1: pick = 16'h7FFF;
                    2: pick = 16'h0000;
                    3: pick = 16'h0001;
                    4: pick = 16'hFFFF;
                    5: pick = 16'h0100;
                    default: pick = 16'hFF00;
                endcase
            end
            else if (kind <= 3)
                pick = WORD_BITS'($urandom_range(0, 2047) - 1024);
            else
                pick = WORD_BITS'($urandom);
            return pick;
        end
    endfunction

    function automatic fpa_pkg::fpa_req_t random_request();
        fpa_pkg::fpa_req_t item;
        begin
            item.command = fpa_pkg::fpa_cmd_t'($urandom_range(0, 3));
            item.operand_a = random_operand();
            item.operand_b = random_operand();
            if (item.command == fpa_pkg::CMD_DIV && $urandom_range(0, 11) == 0)
                item.operand_b = '0;
            return item;
        end
    endfunction

    function automatic void add_row(input fpa_pkg::fpa_cmd_t cmd, input logic [WORD_BITS-1:0] a,
                                    input logic [WORD_BITS-1:0] b, input bit typed,
                                    input logic [WORD_BITS-1:0] word, input bit dz);
        table_row_t row;
        begin
            row.stim.command = cmd;
            row.stim.operand_a = a;
            row.stim.operand_b = b;
            row.typed = typed;
            row.answer.result_word = word;
            row.answer.divide_by_zero = dz;
            item_table.push_back(row);
        end
    endfunction

    task automatic pace();
        fpa_pkg::fpa_req_t noise;
        int unsigned       gap;
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                burst_left = $urandom_range(1, 40);
                if (gap != 0)
                begin
                    noise = random_request();
                    req_valid <= 1'b0;
                    req <= noise;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
        end
    endtask

    task automatic send_item(input table_row_t row);
        begin
            req <= row.stim;
            req_valid <= 1'b1;
            @(posedge clk);
            while (req_stall)
                @(posedge clk);
            if (row.typed)
                pending_results.push_back(row.answer);
            else
                pending_results.push_back(alu_result(row.stim));
            @(negedge clk);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;

        add_row(fpa_pkg::CMD_ADD, 16'h0000, 16'h0000, TYPED, 16'h0000, 1'b0);
        add_row(fpa_pkg::CMD_ADD, 16'h7FFF, 16'h0001, TYPED, 16'h8000, 1'b0);
        add_row(fpa_pkg::CMD_ADD, 16'h8000, 16'h8000, TYPED, 16'h0000, 1'b0);
        add_row(fpa_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, TYPED, 16'hFFFE, 1'b0);
        add_row(fpa_pkg::CMD_SUB, 16'h8000, 16'h0001, TYPED, 16'h7FFF, 1'b0);
        add_row(fpa_pkg::CMD_SUB, 16'h0000, 16'h8000, TYPED, 16'h8000, 1'b0);
        add_row(fpa_pkg::CMD_SUB, 16'h7FFF, 16'hFFFF, TYPED, 16'h8000, 1'b0);
        add_row(fpa_pkg::CMD_MUL, 16'h0100, 16'h0100, TYPED, 16'h0100, 1'b0);
        add_row(fpa_pkg::CMD_MUL, 16'h7FFF, 16'h7FFF, PREDICTED, 16'h0000, 1'b0);
        add_row(fpa_pkg::CMD_MUL, 16'h8000, 16'h8000, TYPED, 16'h0000, 1'b0);
        add_row(fpa_pkg::CMD_MUL, 16'hFFFF, 16'h0001, TYPED, 16'hFFFF, 1'b0);
        add_row(fpa_pkg::CMD_MUL, 16'h8000, 16'h7FFF, PREDICTED, 16'h0000, 1'b0);
        add_row(fpa_pkg::CMD_MUL, 16'hFF00, 16'h0100, TYPED, 16'hFF00, 1'b0);
        add_row(fpa_pkg::CMD_MUL, 16'h0080, 16'h0080, TYPED, 16'h0040, 1'b0);
        add_row(fpa_pkg::CMD_DIV, 16'h0100, 16'h0000, TYPED, 16'h0000, 1'b1);
        add_row(fpa_pkg::CMD_DIV, 16'h8000, 16'h0000, TYPED, 16'h0000, 1'b1);
        add_row(fpa_pkg::CMD_DIV, 16'h0000, 16'h0000, TYPED, 16'h0000, 1'b1);
        add_row(fpa_pkg::CMD_DIV, 16'h0100, 16'h0100, TYPED, 16'h0100, 1'b0);
        add_row(fpa_pkg::CMD_DIV, 16'h8000, 16'hFFFF, PREDICTED, 16'h0000, 1'b0);
        add_row(fpa_pkg::CMD_DIV, 16'h7FFF, 16'h0001, PREDICTED, 16'h0000, 1'b0);
        add_row(fpa_pkg::CMD_DIV, 16'hFFFF, 16'h0200, TYPED, 16'h0000, 1'b0);
        add_row(fpa_pkg::CMD_DIV, 16'h0001, 16'h8000, PREDICTED, 16'h0000, 1'b0);
        add_row(fpa_pkg::CMD_DIV, 16'h8000, 16'h7FFF, PREDICTED, 16'h0000, 1'b0);
        add_row(fpa_pkg::CMD_DIV, 16'hFF00, 16'h0300, PREDICTED, 16'h0000, 1'b0);

        repeat (RANDOM_ITEMS)
        begin
            fpa_pkg::fpa_req_t item;
            item = random_request();
            add_row(item.command, item.operand_a, item.operand_b, PREDICTED, '0, 1'b0);
        end

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        foreach (item_table[i])
        begin
            pace();
            send_item(item_table[i]);
        end
        req_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        int stall_mode;
        int mode_cycle;
        stall_mode = 0;
        mode_cycle = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            mode_cycle++;
            if (mode_cycle == 300)
            begin
                mode_cycle = 0;
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= ($urandom_range(0, 3) == 0);
                2: rsp_stall <= ((mode_cycle % 64) < 20);
                default: rsp_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer: word %h dz %b",
                             rsp.result_word, rsp.divide_by_zero);
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (rsp.result_word !== oldest_result.result_word ||
                    rsp.divide_by_zero !== oldest_result.divide_by_zero)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected word %h dz %b, got word %h dz %b",
                                 oldest_result.result_word, oldest_result.divide_by_zero,
                                 rsp.result_word, rsp.divide_by_zero);
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/fpa_pkg.sv
rtl/fpa_prep.sv
rtl/fpa_div_cell.sv
rtl/fpa_out.sv
rtl/fixed_point_alu_core.sv
rtl/fpa_checker.sv
tb/sv/tb_top.sv
